// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the weight map block.
// Depends on nothing; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define EFW_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen outside reset.
`define EFW_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	`EFW_ASSERT(label, clk, rst_n, !(cond), msg)

`endif

// ===== hw/rtl/efw_pkg.sv =====
// Shared types, constants and helper functions of the exposure fusion weight map.
// Depends on nothing; used by efw_weight and the top level.
package efw_pkg;

	localparam int CH_W     = 16;
	localparam int RGB_W    = 3 * CH_W;
	localparam int GREY_W   = 18;
	localparam int LAP_W    = 20;
	localparam int ROW_W    = 16;
	localparam int OCOL_W   = 11;
	localparam int FW_W     = 12;
	localparam int CFG_W    = 16;
	localparam int WEIGHT_W = 32;
	localparam int EXP_W    = 17;

	localparam int EXP_DEPTH = 1024;
	localparam int EXP_IDX_W = $clog2(EXP_DEPTH);
	localparam longint unsigned EXP_D  = EXP_DEPTH;
	localparam longint unsigned EXP_D2 = EXP_D * EXP_D;
	localparam longint unsigned Q31_ONE = 64'd1 << 31;

	localparam logic [15:0] FRAME_RESET = 16'd2048;

	typedef enum logic [0:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		T_IDLE, T_RD, T_CALC, T_LAP, T_START, T_WAIT
	} top_state_t;

	typedef enum logic [3:0] {
		W_IDLE, W_RR, W_GG, W_BB, W_SS, W_SQRT, W_DIV, W_WE1, W_WE2, W_SW, W_LAP, W_DONE
	} wu_state_t;

	typedef struct packed {
		logic [RGB_W-1:0] rgb;
		logic [LAP_W-1:0] lap;
	} efw_job_t;

	typedef struct packed {
		logic start;
		logic take;
	} wu_ctrl_t;

	typedef struct packed {
		logic done;
	} wu_stat_t;

	typedef logic [EXP_W-1:0] exp_entry_t;
	typedef exp_entry_t exp_rom_t [EXP_DEPTH];

	function automatic exp_rom_t build_exp_rom();
		exp_rom_t rom;
		longint unsigned a;
		longint unsigned m;
		longint unsigned y;
		longint unsigned t;
		for (int k = 0; k < EXP_DEPTH; k++) begin
			a = 64'(2 * k + 1);
			m = (a >= EXP_D) ? a - EXP_D : EXP_D - a;
			y = (((64'd25 * m * m) << 24) + EXP_D2 / 2) / EXP_D2;
			t = Q31_ONE;
			t = Q31_ONE - ((y * t) >> 31) / 6;
			t = Q31_ONE - ((y * t) >> 31) / 5;
			t = Q31_ONE - ((y * t) >> 31) / 4;
			t = Q31_ONE - ((y * t) >> 31) / 3;
			t = Q31_ONE - ((y * t) >> 31) / 2;
			t = Q31_ONE - ((y * t) >> 31);
			for (int s = 0; s < 4; s++)
				t = (t * t + (64'd1 << 30)) >> 31;
			rom[k] = EXP_W'((t + 64'd16384) >> 15);
		end
		return rom;
	endfunction

	localparam exp_rom_t EXP_ROM = build_exp_rom();

	// Luma in Q0.18, rounded.
	function automatic logic [GREY_W-1:0] grey_of(input logic [RGB_W-1:0] p);
		logic [33:0] s;
		s = 34'(p[15:0]) * 34'd19588 + 34'(p[31:16]) * 34'd38470
			+ 34'(p[47:32]) * 34'd7471 + 34'd8192;
		return GREY_W'(s >> 14);
	endfunction

	// Absolute four-neighbour Laplacian.
	function automatic logic [LAP_W-1:0] lap_abs(input logic [GREY_W-1:0] c,
			input logic [GREY_W-1:0] t, input logic [GREY_W-1:0] l,
			input logic [GREY_W-1:0] r, input logic [GREY_W-1:0] b);
		logic [LAP_W:0] pos;
		logic [LAP_W:0] neg;
		pos = (LAP_W+1)'(t) + (LAP_W+1)'(l) + (LAP_W+1)'(r) + (LAP_W+1)'(b);
		neg = (LAP_W+1)'(c) << 2;
		return (pos >= neg) ? LAP_W'(pos - neg) : LAP_W'(neg - pos);
	endfunction

endpackage

// ===== hw/rtl/efw_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read per cycle.
// Depends on nothing.
module efw_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/efw_weight.sv =====
// Multi-cycle weight unit: saturation, well-exposedness and the final product.
// Depends on efw_pkg; one shared multiplier and a bit-serial square root.
module efw_weight (
	input  logic                          clk,
	input  logic                          arst_n,
	input  efw_pkg::wu_ctrl_t             ctrl,
	input  efw_pkg::efw_job_t             job,
	output efw_pkg::wu_stat_t             stat,
	output logic [efw_pkg::WEIGHT_W-1:0]  weight
);

	efw_pkg::wu_state_t state_q, state_d;

	logic [15:0] r_q, g_q, b_q;
	logic [efw_pkg::LAP_W-1:0] lap_q;
	logic [33:0] acc_q;
	logic [43:0] rem_q, root_q, bit_q;
	logic [efw_pkg::EXP_W-1:0] rom_q, er_q, eg_q, eb_q, we_q;
	logic [20:0] sat_q;
	logic [37:0] prod_q;
	logic [efw_pkg::WEIGHT_W-1:0] wt_q;

	logic [37:0] mul_a;
	logic [23:0] mul_b;
	logic [61:0] mul_p;
	logic [15:0] rom_ch;
	logic [17:0] csum;
	logic [35:0] var_v;
	logic [43:0] trial;
	logic [33:0] rounded;

	assign mul_p = 62'(mul_a) * 62'(mul_b);
	assign csum = 18'(r_q) + 18'(g_q) + 18'(b_q);
	assign var_v = 36'(acc_q) + (36'(acc_q) << 1) - 36'(mul_p);
	assign trial = root_q + bit_q;
	assign rounded = 34'((mul_p + 62'd33554432) >> 26) + 34'd1;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		rom_ch = r_q;
		unique case (state_q)
			efw_pkg::W_RR: begin
				mul_a = 38'(r_q);
				mul_b = 24'(r_q);
			end
			efw_pkg::W_GG: begin
				mul_a = 38'(g_q);
				mul_b = 24'(g_q);
				rom_ch = g_q;
			end
			efw_pkg::W_BB: begin
				mul_a = 38'(b_q);
				mul_b = 24'(b_q);
				rom_ch = b_q;
			end
			efw_pkg::W_SS: begin
				mul_a = 38'(csum);
				mul_b = 24'(csum);
			end
			efw_pkg::W_DIV: begin
				mul_a = 38'(root_q[22:0]) + 38'd1;
				mul_b = 24'hAAAAAB;
			end
			efw_pkg::W_WE1: begin
				mul_a = 38'(er_q);
				mul_b = 24'(eg_q);
			end
			efw_pkg::W_WE2: begin
				mul_a = 38'(we_q);
				mul_b = 24'(eb_q);
			end
			efw_pkg::W_SW: begin
				mul_a = 38'(sat_q);
				mul_b = 24'(we_q);
			end
			efw_pkg::W_LAP: begin
				mul_a = prod_q;
				mul_b = 24'(lap_q);
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			efw_pkg::W_IDLE: if (ctrl.start) state_d = efw_pkg::W_RR;
			efw_pkg::W_RR:   state_d = efw_pkg::W_GG;
			efw_pkg::W_GG:   state_d = efw_pkg::W_BB;
			efw_pkg::W_BB:   state_d = efw_pkg::W_SS;
			efw_pkg::W_SS:   state_d = efw_pkg::W_SQRT;
			efw_pkg::W_SQRT: if (bit_q[0]) state_d = efw_pkg::W_DIV;
			efw_pkg::W_DIV:  state_d = efw_pkg::W_WE1;
			efw_pkg::W_WE1:  state_d = efw_pkg::W_WE2;
			efw_pkg::W_WE2:  state_d = efw_pkg::W_SW;
			efw_pkg::W_SW:   state_d = efw_pkg::W_LAP;
			efw_pkg::W_LAP:  state_d = efw_pkg::W_DONE;
			efw_pkg::W_DONE: if (ctrl.take) state_d = efw_pkg::W_IDLE;
			default:         state_d = efw_pkg::W_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= efw_pkg::W_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		rom_q <= efw_pkg::EXP_ROM[rom_ch[15 -: efw_pkg::EXP_IDX_W]];
		unique case (state_q)
			efw_pkg::W_IDLE: begin
				r_q <= job.rgb[15:0];
				g_q <= job.rgb[31:16];
				b_q <= job.rgb[47:32];
				lap_q <= job.lap;
			end
			efw_pkg::W_RR: acc_q <= 34'(mul_p);
			efw_pkg::W_GG: begin
				acc_q <= acc_q + 34'(mul_p);
				er_q <= rom_q;
			end
			efw_pkg::W_BB: begin
				acc_q <= acc_q + 34'(mul_p);
				eg_q <= rom_q;
			end
			efw_pkg::W_SS: begin
				eb_q <= rom_q;
				rem_q <= {var_v, 8'd0};
				root_q <= '0;
				bit_q <= 44'd1 << 42;
			end
			efw_pkg::W_SQRT: begin
				if (rem_q >= trial) begin
					rem_q <= rem_q - trial;
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			efw_pkg::W_DIV: sat_q <= 21'(mul_p >> 25);
			efw_pkg::W_WE1: we_q <= efw_pkg::EXP_W'((mul_p + 62'd32768) >> 16);
			efw_pkg::W_WE2: we_q <= efw_pkg::EXP_W'((mul_p + 62'd32768) >> 16);
			efw_pkg::W_SW:  prod_q <= 38'(mul_p);
			efw_pkg::W_LAP: wt_q <= rounded[33:32] != 2'd0 ? '1 : rounded[31:0];
			default: ;
		endcase
	end

	assign stat.done = (state_q == efw_pkg::W_DONE);
	assign weight = wt_q;

endmodule

// ===== hw/rtl/exposure_fusion_weight_map_unit.sv =====
// Top level of the exposure fusion weight map: line stores, sequencer, output register.
// Depends on efw_pkg, efw_ram, efw_weight and assert_macros.svh.
//
// Usage:
//   Pixels enter on in_valid/in_ready (red, green, blue, Q0.16) in raster order.
//   Each pixel transfer yields zero to three weights on out_valid/out_ready:
//   the pixel one row up at this column, then on the last row the pixel to the
//   left, then at the end of the last row this pixel (frame_end set).
//   last_of_run marks the final weight caused by one input pixel.
//   The first row produces no weights; output lags the input by one row.
//   Each pixel first goes through the line-store reads and writes, then each of its
//   weights in turn through the weight unit, whose longest step is the bit-serial
//   square root; a middle-row pixel needs one such pass, lengthened by any output stall.
//   in_ready is high only while the sequencer is idle; the last weight of a
//   pixel may still wait in the output register while the next pixel transfers.
//   A receiver stall holds the output register and, behind it, the sequencer.
//   The user must write configuration (frame_width, frame_height) via cfg_we only while
//   the block is idle, which it does not enforce; it takes effect on the next pixel.
//   Reset clears row and column counters and sets both sizes to 2048; the line
//   stores need no clearing since the first row only writes them.
`include "assert_macros.svh"

module exposure_fusion_weight_map_unit #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [0:0]                     cfg_index,
	input  logic [efw_pkg::CFG_W-1:0]      cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [efw_pkg::CH_W-1:0]       red,
	input  logic [efw_pkg::CH_W-1:0]       green,
	input  logic [efw_pkg::CH_W-1:0]       blue,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [efw_pkg::WEIGHT_W-1:0]   weight,
	output logic [efw_pkg::ROW_W-1:0]      out_row,
	output logic [efw_pkg::OCOL_W-1:0]     out_col,
	output logic                           last_of_run,
	output logic                           frame_end
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int MW_W  = $clog2(MAX_WIDTH + 1);
	localparam int CMP_W = (efw_pkg::FW_W > MW_W ? efw_pkg::FW_W : MW_W) + 1;
	localparam int XC_W  = COL_W + efw_pkg::OCOL_W;

	efw_pkg::top_state_t state_q, state_d;

	// configuration
	logic [efw_pkg::FW_W-1:0]  fw_q;
	logic [efw_pkg::ROW_W-1:0] fh_q;
	logic [CMP_W-1:0] eff_w;
	logic [efw_pkg::ROW_W-1:0] eff_h;

	// position counters
	logic [efw_pkg::ROW_W-1:0] row_cnt_q;
	logic [COL_W-1:0]          col_cnt_q;
	logic [CMP_W-1:0]          col_p1;
	logic                      last_col_n, last_row_n;

	// current pixel context
	logic [efw_pkg::RGB_W-1:0]  px_q, cen_q, prev_rgb_q;
	logic [efw_pkg::ROW_W-1:0]  cur_row_q;
	logic [COL_W-1:0]           cur_col_q;
	logic                       last_col_q, last_row_q;
	logic [efw_pkg::GREY_W-1:0] top_raw_q, gc_q, gin_q, gr_q;
	logic [efw_pkg::GREY_W-1:0] gprev_q, gprev2_q, lgrey_q;

	// queued weight jobs
	efw_pkg::efw_job_t          job_q [3];
	logic [efw_pkg::ROW_W-1:0]  job_row_q [3];
	logic [COL_W-1:0]           job_col_q [3];
	logic [2:0]                 job_en_q, job_en_d;
	logic [1:0]                 job_idx_q, job_first, job_next;
	logic                       has_next;
	logic                       load_jobs;

	// line stores
	logic [efw_pkg::RGB_W-1:0]  rgb_rdata;
	logic [efw_pkg::GREY_W-1:0] grey_rdata;
	logic [COL_W-1:0]           rd_addr;
	logic                       rgb_we, grey_we;

	// weight unit
	efw_pkg::wu_ctrl_t          wu_ctrl;
	efw_pkg::wu_stat_t          wu_stat;
	logic [efw_pkg::WEIGHT_W-1:0] wu_weight;

	// output register
	logic                       out_valid_q, out_load, out_free;
	logic [efw_pkg::WEIGHT_W-1:0] weight_q;
	logic [efw_pkg::ROW_W-1:0]  out_row_q;
	logic [efw_pkg::OCOL_W-1:0] out_col_q;
	logic                       last_q, fe_q;
	logic [XC_W-1:0]            col_ext;

	logic in_xfer;
	logic [efw_pkg::LAP_W-1:0] lap0, lap1, lap2;

	assign in_xfer = in_valid && in_ready;
	assign in_ready = (state_q == efw_pkg::T_IDLE);

	// Clamp the width into [2, MAX_WIDTH] and the height to at least 2.
	always_comb begin
		if (fw_q < efw_pkg::FW_W'(2))
			eff_w = CMP_W'(2);
		else if (CMP_W'(fw_q) > CMP_W'(MAX_WIDTH))
			eff_w = CMP_W'(MAX_WIDTH);
		else
			eff_w = CMP_W'(fw_q);
		eff_h = (fh_q < efw_pkg::ROW_W'(2)) ? efw_pkg::ROW_W'(2) : fh_q;
	end

	assign col_p1 = CMP_W'(col_cnt_q) + CMP_W'(1);
	assign last_col_n = col_p1 >= eff_w;
	assign last_row_n = (17'(row_cnt_q) + 17'd1) >= 17'(eff_h);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= efw_pkg::FW_W'(efw_pkg::FRAME_RESET);
			fh_q <= efw_pkg::FRAME_RESET;
		end else if (cfg_we) begin
			unique case (efw_pkg::cfg_reg_t'(cfg_index))
				efw_pkg::REG_FRAME_WIDTH:  fw_q <= cfg_data[efw_pkg::FW_W-1:0];
				efw_pkg::REG_FRAME_HEIGHT: fh_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance the raster position on every pixel transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_cnt_q <= '0;
			col_cnt_q <= '0;
		end else if (in_xfer) begin
			if (last_col_n) begin
				col_cnt_q <= '0;
				row_cnt_q <= last_row_n ? '0 : row_cnt_q + efw_pkg::ROW_W'(1);
			end else begin
				col_cnt_q <= col_cnt_q + COL_W'(1);
			end
		end
	end

	// Line stores: read the centre column at transfer, the right neighbour next.
	assign rd_addr = (state_q == efw_pkg::T_RD) ? cur_col_q + COL_W'(1) : col_cnt_q;
	assign load_jobs = (state_q == efw_pkg::T_LAP);
	assign rgb_we = load_jobs;
	assign grey_we = load_jobs && (cur_row_q != '0);

	efw_ram #(.WIDTH(efw_pkg::RGB_W), .DEPTH(MAX_WIDTH)) u_rgb_line (
		.clk   (clk),
		.we    (rgb_we),
		.waddr (cur_col_q),
		.wdata (px_q),
		.raddr (rd_addr),
		.rdata (rgb_rdata)
	);

	efw_ram #(.WIDTH(efw_pkg::GREY_W), .DEPTH(MAX_WIDTH)) u_grey_line (
		.clk   (clk),
		.we    (grey_we),
		.waddr (cur_col_q),
		.wdata (gc_q),
		.raddr (rd_addr),
		.rdata (grey_rdata)
	);

	// Laplacians of the up to three pixels finished by this transfer.
	always_comb begin
		lap0 = efw_pkg::lap_abs(gc_q,
			(cur_row_q > efw_pkg::ROW_W'(1)) ? top_raw_q : gc_q,
			(cur_col_q != '0) ? lgrey_q : gc_q,
			!last_col_q ? gr_q : gc_q,
			gin_q);
		lap1 = efw_pkg::lap_abs(gprev_q,
			lgrey_q,
			(cur_col_q > COL_W'(1)) ? gprev2_q : gprev_q,
			(CMP_W'(cur_col_q) < eff_w) ? gin_q : gprev_q,
			gprev_q);
		lap2 = efw_pkg::lap_abs(gin_q,
			(cur_row_q != '0) ? gc_q : gin_q,
			(cur_col_q != '0) ? gprev_q : gin_q,
			gin_q,
			gin_q);
		job_en_d = {last_row_q && last_col_q,
			last_row_q && (cur_col_q != '0),
			cur_row_q != '0};
		job_first = job_en_d[0] ? 2'd0 : (job_en_d[1] ? 2'd1 : 2'd2);
	end

	// Next queued job after the one in flight.
	always_comb begin
		has_next = 1'b0;
		job_next = job_idx_q;
		unique case (job_idx_q)
			2'd0: begin
				has_next = job_en_q[1] || job_en_q[2];
				job_next = job_en_q[1] ? 2'd1 : 2'd2;
			end
			2'd1: begin
				has_next = job_en_q[2];
				job_next = 2'd2;
			end
			default: ;
		endcase
	end

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		wu_ctrl = '0;
		out_load = 1'b0;
		unique case (state_q)
			efw_pkg::T_IDLE: if (in_xfer) state_d = efw_pkg::T_RD;
			efw_pkg::T_RD:   state_d = efw_pkg::T_CALC;
			efw_pkg::T_CALC: state_d = efw_pkg::T_LAP;
			efw_pkg::T_LAP:  state_d = (job_en_d != '0) ? efw_pkg::T_START : efw_pkg::T_IDLE;
			efw_pkg::T_START: begin
				wu_ctrl.start = 1'b1;
				state_d = efw_pkg::T_WAIT;
			end
			efw_pkg::T_WAIT: begin
				// hold the finished weight until the output register frees up
				if (wu_stat.done && out_free) begin
					wu_ctrl.take = 1'b1;
					out_load = 1'b1;
					state_d = has_next ? efw_pkg::T_START : efw_pkg::T_IDLE;
				end
			end
			default: state_d = efw_pkg::T_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= efw_pkg::T_IDLE;
			job_en_q <= '0;
			job_idx_q <= '0;
			prev_rgb_q <= '0;
			gprev_q <= '0;
			gprev2_q <= '0;
			lgrey_q <= '0;
		end else begin
			state_q <= state_d;
			if (load_jobs) begin
				job_en_q <= job_en_d;
				job_idx_q <= job_first;
				prev_rgb_q <= px_q;
				gprev2_q <= gprev_q;
				gprev_q <= gin_q;
				if (cur_row_q != '0)
					lgrey_q <= gc_q;
			end else if (out_load) begin
				job_idx_q <= job_next;
			end
		end
	end

	// Pixel context and job payloads.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			px_q <= {blue, green, red};
			cur_row_q <= row_cnt_q;
			cur_col_q <= col_cnt_q;
			last_col_q <= last_col_n;
			last_row_q <= last_row_n;
		end
		if (state_q == efw_pkg::T_RD) begin
			cen_q <= rgb_rdata;
			top_raw_q <= grey_rdata;
			gc_q <= efw_pkg::grey_of(rgb_rdata);
			gin_q <= efw_pkg::grey_of(px_q);
		end
		if (state_q == efw_pkg::T_CALC)
			gr_q <= efw_pkg::grey_of(rgb_rdata);
		if (load_jobs) begin
			job_q[0] <= '{rgb: cen_q, lap: lap0};
			job_q[1] <= '{rgb: prev_rgb_q, lap: lap1};
			job_q[2] <= '{rgb: px_q, lap: lap2};
			job_row_q[0] <= cur_row_q - efw_pkg::ROW_W'(1);
			job_row_q[1] <= cur_row_q;
			job_row_q[2] <= cur_row_q;
			job_col_q[0] <= cur_col_q;
			job_col_q[1] <= cur_col_q - COL_W'(1);
			job_col_q[2] <= cur_col_q;
		end
	end

	efw_weight u_weight (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (wu_ctrl),
		.job    (job_q[job_idx_q]),
		.stat   (wu_stat),
		.weight (wu_weight)
	);

	// Output register: load a finished weight, drop it on transfer.
	assign col_ext = XC_W'(job_col_q[job_idx_q]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			weight_q <= wu_weight;
			out_row_q <= job_row_q[job_idx_q];
			out_col_q <= col_ext[efw_pkg::OCOL_W-1:0];
			last_q <= !has_next;
			fe_q <= (job_idx_q == 2'd2);
		end
	end

	assign out_valid = out_valid_q;
	assign weight = weight_q;
	assign out_row = out_row_q;
	assign out_col = out_col_q;
	assign last_of_run = last_q;
	assign frame_end = fe_q;

	`EFW_ASSERT(a_weight_nonzero, clk, arst_n, out_valid |-> (weight != '0), "zero weight shown")
	`EFW_ASSERT(a_frame_end_last, clk, arst_n, (out_valid && frame_end) |-> last_of_run, "frame end not last of run")
	`EFW_ASSERT(a_load_from_wait, clk, arst_n, $rose(out_valid) |-> $past(state_q == efw_pkg::T_WAIT), "output loaded outside wait")
	`EFW_ASSERT_NEVER(a_accept_unit_busy, clk, arst_n, in_valid && in_ready && wu_stat.done, "pixel taken with weight pending")

endmodule

// ===== tb/sv/exposure_fusion_weight_map_unit_test.sv =====
// Self-checking testbench for exposure_fusion_weight_map_unit: raster pixel frames in,
// weights checked in order against a built-in fixed-point weight predictor.
// Depends on efw_pkg and the RTL of the weight map block only.
`timescale 1ns / 100ps

module exposure_fusion_weight_map_unit_test;

	localparam int LINE_MAX = 2048;
	localparam int TAB_N = 1024;
	localparam int SETTLE = 120;     // longer than the slowest pixel takes

	typedef struct {
		logic [31:0] w;
		logic [15:0] row;
		logic [10:0] col;
		logic        last;
		logic        fend;
	} weight_rec_t;

	// Directed stimulus: one pixel per row; typed weight applies to every result it causes.
	typedef struct {
		logic [15:0] r;
		logic [15:0] g;
		logic [15:0] b;
		logic        typed;
		logic [31:0] w;
	} pix_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_index = efw_pkg::REG_FRAME_WIDTH;
	logic [efw_pkg::CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [15:0] red = '0, green = '0, blue = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [31:0] weight;
	logic [15:0] out_row;
	logic [10:0] out_col;
	logic last_of_run, frame_end;

	exposure_fusion_weight_map_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.red(red), .green(green), .blue(blue),
		.out_valid(out_valid), .out_ready(out_ready),
		.weight(weight), .out_row(out_row), .out_col(out_col),
		.last_of_run(last_of_run), .frame_end(frame_end)
	);

	always #10 clk = ~clk;

	// Predictor state: line stores, counters, left-hand holds and sizes.
	logic [47:0] line_px [LINE_MAX];
	logic [17:0] line_luma [LINE_MAX];
	int unsigned row_pos, col_pos;
	logic [47:0] left_px;
	logic [17:0] left_luma;
	int unsigned width_reg, height_reg;
	logic [16:0] gauss_tab [TAB_N];

	weight_rec_t pending_weights [$];
	int errors = 0;
	bit long_hold_req = 0;

	// Build the well-exposedness table: truncated series of exp(-y), squared four times.
	function automatic void fill_gauss();
		longint unsigned d2, a, m, y, t;
		d2 = longint'(TAB_N) * TAB_N;
		for (int k = 0; k < TAB_N; k++) begin
			a = 2 * k + 1;
			m = (a >= TAB_N) ? a - TAB_N : TAB_N - a;
			y = (((64'd25 * m * m) << 24) + d2 / 2) / d2;
			t = 64'd1 << 31;
			for (int j = 6; j >= 1; j--)
				t = (64'd1 << 31) - ((y * t) >> 31) / j;
			for (int s = 0; s < 4; s++)
				t = (t * t + (64'd1 << 30)) >> 31;
			gauss_tab[k] = 17'((t + 64'd16384) >> 15);
		end
	endfunction

	function automatic logic [17:0] luma(logic [47:0] p);
		longint unsigned s;
		s = 64'd19588 * p[15:0] + 64'd38470 * p[31:16] + 64'd7471 * p[47:32];
		return 18'((s + 64'd8192) >> 14);
	endfunction

	function automatic logic [19:0] abs_laplace(logic [17:0] c, logic [17:0] t,
			logic [17:0] l, logic [17:0] r, logic [17:0] b);
		longint unsigned up, dn;
		up = longint'(t) + l + r + b;
		dn = 4 * longint'(c);
		return 20'((up >= dn) ? up - dn : dn - up);
	endfunction

	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned res, bit_w;
		res = 0;
		bit_w = 64'd1 << 62;
		while (bit_w > v)
			bit_w >>= 2;
		while (bit_w != 0) begin
			if (v >= res + bit_w) begin
				v -= res + bit_w;
				res = (res >> 1) + bit_w;
			end else begin
				res >>= 1;
			end
			bit_w >>= 2;
		end
		return res;
	endfunction

	function automatic logic [31:0] pixel_weight(logic [47:0] p, logic [19:0] lap);
		longint unsigned r, g, b, s, v, sat, we, w;
		r = p[15:0];
		g = p[31:16];
		b = p[47:32];
		s = r + g + b;
		v = 3 * (r * r + g * g + b * b) - s * s;
		sat = (floor_sqrt(v << 8) + 1) / 3;
		we = (longint'(gauss_tab[(r * TAB_N) >> 16]) * gauss_tab[(g * TAB_N) >> 16]
			+ 32768) >> 16;
		we = (we * gauss_tab[(b * TAB_N) >> 16] + 32768) >> 16;
		w = ((sat * we * lap + (64'd1 << 25)) >> 26) + 1;
		return (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(w);
	endfunction

	// Advance the predictor by one accepted pixel and queue the weights it releases.
	function automatic void predict_weights(logic [47:0] px, logic typed, logic [31:0] tw);
		weight_rec_t run [$];
		weight_rec_t rec;
		int unsigned w, h, row, col, c1;
		logic lastc, lastr;
		logic [17:0] gin, gab, gc, top, lft, rgt;
		logic [47:0] prev;
		w = (width_reg < 2) ? 2 : ((width_reg > LINE_MAX) ? LINE_MAX : width_reg);
		h = (height_reg < 2) ? 2 : height_reg;
		row = row_pos;
		col = col_pos;
		lastc = (col + 1 >= w);
		lastr = (row + 1 >= h);
		gin = luma(px);
		prev = left_px;
		gab = gin;
		if (row >= 1) begin
			gc = luma(line_px[col]);
			top = (row >= 2) ? line_luma[col] : gc;
			lft = (col > 0) ? left_luma : gc;
			rgt = !lastc ? luma(line_px[col + 1]) : gc;
			rec = '{pixel_weight(line_px[col], abs_laplace(gc, top, lft, rgt, gin)),
				16'(row - 1), 11'(col), 1'b0, 1'b0};
			run.push_back(rec);
			line_luma[col] = gc;
			left_luma = gc;
			gab = gc;
		end
		line_px[col] = px;
		left_px = px;
		if (lastr) begin
			// last row: flush the pixel to the left now that its right neighbour is known
			if (col >= 1) begin
				c1 = col - 1;
				gc = luma(prev);
				lft = (c1 > 0) ? luma(line_px[c1 - 1]) : gc;
				rgt = (c1 + 1 < w) ? gin : gc;
				rec = '{pixel_weight(prev, abs_laplace(gc, line_luma[c1], lft, rgt, gc)),
					16'(row), 11'(c1), 1'b0, 1'b0};
				run.push_back(rec);
			end
			if (lastc) begin
				lft = (col > 0) ? luma(prev) : gin;
				rec = '{pixel_weight(px, abs_laplace(gin, gab, lft, gin, gin)),
					16'(row), 11'(col), 1'b0, 1'b1};
				run.push_back(rec);
			end
		end
		if (lastc) begin
			col_pos = 0;
			row_pos = lastr ? 0 : ((row + 1) & 16'hFFFF);
		end else begin
			col_pos = col + 1;
		end
		if (run.size() > 0)
			run[run.size() - 1].last = 1'b1;
		foreach (run[i]) begin
			if (typed)
				run[i].w = tw;
			pending_weights.push_back(run[i]);
		end
	endfunction

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		$display("[%0t] mismatch %s: got %0h want %0h", $time, what, got, want);
		errors++;
	endtask

	// Check each output transfer against the oldest pending weight.
	always @(posedge clk) begin
		weight_rec_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_weights.size() == 0) begin
				report_mismatch("unexpected weight at row/col", {out_row, 5'd0, out_col}, 0);
			end else begin
				e = pending_weights.pop_front();
				if (weight !== e.w) report_mismatch("weight", weight, e.w);
				if (out_row !== e.row) report_mismatch("out_row", out_row, e.row);
				if (out_col !== e.col) report_mismatch("out_col", out_col, e.col);
				if (last_of_run !== e.last) report_mismatch("last_of_run", last_of_run, e.last);
				if (frame_end !== e.fend) report_mismatch("frame_end", frame_end, e.fend);
			end
		end
	end

	// Receiver: random hold-off before each transfer, one long hold-off on request.
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			n = $urandom_range(0, 10);
			if ($urandom_range(0, 3) == 0)
				n = 0;          // stretches with no stall
			if (long_hold_req) begin
				n = 400;        // hold long enough for the input to back up
				long_hold_req = 0;
			end
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	// Drive one pixel transfer after a random gap; leave valid high for a back-to-back pixel.
	task automatic send_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b,
			logic typed = 1'b0, logic [31:0] tw = '0);
		int n;
		n = $urandom_range(0, 10);
		if ($urandom_range(0, 3) == 0)
			n = 0;
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1'b1;
		red <= r;
		green <= g;
		blue <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_weights({b, g, r}, typed, tw);
	endtask

	// Drop valid and wait until every weight is out and the sequencer has settled.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_weights.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_frame(int unsigned w, int unsigned h);
		cfg_we <= 1'b1;
		cfg_index <= efw_pkg::REG_FRAME_WIDTH;
		cfg_data <= efw_pkg::CFG_W'(w);
		@(posedge clk);
		cfg_index <= efw_pkg::REG_FRAME_HEIGHT;
		cfg_data <= efw_pkg::CFG_W'(h);
		@(posedge clk);
		cfg_we <= 1'b0;
		width_reg = w & 12'hFFF;
		height_reg = h & 16'hFFFF;
	endtask

	function automatic logic [15:0] rand_chan();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h8000 + 16'($urandom_range(0, 4095)) - 16'd2048;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// Send n random pixels; optionally pause for a full drain halfway.
	task automatic send_random(int unsigned n, bit mid_pause = 0);
		for (int unsigned i = 0; i < n; i++) begin
			if (mid_pause && i == n / 2) begin
				in_valid <= 1'b0;
				while (pending_weights.size() != 0)
					@(posedge clk);
			end
			send_pixel(rand_chan(), rand_chan(), rand_chan());
		end
	endtask

	initial begin
		#(40_000_000);
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		pix_row_t grey_frame [4];
		pix_row_t edge_frame [9];
		int unsigned sent, w, h, frames;
		fill_gauss();
		row_pos = 0;
		col_pos = 0;
		left_px = '0;
		left_luma = '0;
		width_reg = efw_pkg::FRAME_RESET;
		height_reg = efw_pkg::FRAME_RESET;

		// equal channels have no saturation, so every weight is the floor of one
		grey_frame = '{
			'{16'h0000, 16'h0000, 16'h0000, 1'b0, 32'd0},
			'{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 32'd0},
			'{16'h8000, 16'h8000, 16'h8000, 1'b1, 32'd1},
			'{16'h1234, 16'h1234, 16'h1234, 1'b1, 32'd1}
		};
		// channel extremes, full-scale swings for large Laplacians
		edge_frame = '{
			'{16'hFFFF, 16'h0000, 16'h0000, 1'b0, 32'd0},
			'{16'h0000, 16'hFFFF, 16'h0000, 1'b0, 32'd0},
			'{16'h0000, 16'h0000, 16'hFFFF, 1'b0, 32'd0},
			'{16'h0000, 16'h0000, 16'h0000, 1'b0, 32'd0},
			'{16'hFFFF, 16'h8000, 16'h0000, 1'b0, 32'd0},
			'{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 32'd0},
			'{16'h8000, 16'h0000, 16'hFFFF, 1'b0, 32'd0},
			'{16'h0000, 16'hFFFF, 16'h8000, 1'b0, 32'd0},
			'{16'hFFFF, 16'h0000, 16'hFFFF, 1'b0, 32'd0}
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_frame(2, 2);
		foreach (grey_frame[i])
			send_pixel(grey_frame[i].r, grey_frame[i].g, grey_frame[i].b,
				grey_frame[i].typed, grey_frame[i].w);
		drain();

		set_frame(3, 3);
		foreach (edge_frame[i])
			send_pixel(edge_frame[i].r, edge_frame[i].g, edge_frame[i].b);
		drain();

		// sizes below range act as 2x2
		set_frame(0, 0);
		send_random(4);
		drain();

		// random frames; the second holds the output long, the third pauses for a drain
		sent = 0;
		frames = 0;
		while (sent < 100) begin
			w = $urandom_range(2, 9);
			h = $urandom_range(2, 5);
			set_frame(w, h);
			if (frames == 1)
				long_hold_req = 1;
			send_random(w * h, frames == 2);
			drain();
			sent += w * h;
			frames++;
		end

		// width above range acts as the full line store; start a short first row only
		set_frame(4095, 2);
		send_random(6);
		drain();

		// tallest frame: the partial row above ends at the new width, then a few rows
		set_frame(2, 65535);
		send_random(6);
		drain();

		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/efw_pkg.sv
hw/rtl/efw_ram.sv
hw/rtl/efw_weight.sv
hw/rtl/exposure_fusion_weight_map_unit.sv
tb/sv/exposure_fusion_weight_map_unit_test.sv
